/* src/gcd_pkg.sv */
// Shared types, constants and arithmetic helpers for the great circle distance pipeline.
package gcd_pkg;

    // Fixed-point format and pipeline geometry.
    localparam int FRAC_BITS = 30;
    localparam int CW        = FRAC_BITS + 4;
    localparam int ZW        = 36;
    localparam int VW        = 35;
    localparam int ITER      = 32;
    localparam int LANES     = 4;
    localparam int SQW       = 63;
    localparam int RW        = 32;
    localparam int RADW      = 24;
    localparam int DISTW     = 26;
    localparam int ANGW      = 32;

    typedef logic signed [CW-1:0]     t_cw;
    typedef logic        [CW-1:0]     t_mag;
    typedef logic        [2*CW-1:0]   t_prod;
    typedef logic signed [ZW-1:0]     t_zw;
    typedef logic signed [VW-1:0]     t_vw;
    typedef logic signed [ANGW:0]     t_ang;
    typedef logic        [FRAC_BITS:0] t_frac;
    typedef logic        [SQW-1:0]    t_sq;
    typedef logic        [RW-1:0]     t_root;

    // Reciprocal of the CORDIC gain, rounded half up to the fraction width.
    localparam longint unsigned INV_GAIN_32 = 64'h9B74EDA8;
    localparam longint unsigned INV_GAIN    = (FRAC_BITS >= 32) ?
        (INV_GAIN_32 << (FRAC_BITS - 32)) :
        ((INV_GAIN_32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

    localparam t_zw           QUARTER      = t_zw'(64'd2147483648);
    localparam t_zw           HALF         = t_zw'(64'd4294967296);
    localparam t_frac         ONE          = t_frac'(1) << FRAC_BITS;
    localparam logic [31:0]   TWO_PI_Q29   = 32'd3373259426;
    localparam logic [RADW-1:0] RADIUS_RESET = 24'd6371000;
    localparam logic [DISTW-1:0] DIST_MAX  = '1;

    // Arctangent of 2^-k in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TAB [ITER] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Angle step of one CORDIC iteration in units of 2^-33 turn.
    function automatic t_zw atan_step(input int k);
        return t_zw'({ATAN_TAB[k], 1'b0});
    endfunction

    // Magnitude of a signed fixed-point value.
    function automatic t_mag mag(input t_cw v);
        return v[CW-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    // Round a magnitude product half up to the fraction width, then apply the sign.
    function automatic t_cw qround(input t_prod p, input logic neg);
        t_prod s;
        t_cw   r;
        s = p + (t_prod'(1) << (FRAC_BITS - 1));
        r = t_cw'(s >> FRAC_BITS);
        return neg ? -r : r;
    endfunction

endpackage

/* src/gcd_sincos.sv */
// Four-lane unrolled rotation CORDIC giving sine and cosine of binary angles.
module gcd_sincos (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  gcd_pkg::t_ang     i_angle [gcd_pkg::LANES],
    output logic              o_valid,
    output gcd_pkg::t_cw      o_sin [2],
    output gcd_pkg::t_cw      o_cos [2]
);

    gcd_pkg::t_cw r_x   [gcd_pkg::ITER+1][gcd_pkg::LANES];
    gcd_pkg::t_cw r_y   [gcd_pkg::ITER+1][gcd_pkg::LANES];
    gcd_pkg::t_zw r_z   [gcd_pkg::ITER+1][gcd_pkg::LANES];
    logic         r_neg [gcd_pkg::ITER+1][gcd_pkg::LANES];
    logic [gcd_pkg::ITER:0] r_valid;
    logic         r_out_valid;
    gcd_pkg::t_cw r_sin [2];
    gcd_pkg::t_cw r_cos [2];
    gcd_pkg::t_zw n_z0  [gcd_pkg::LANES];
    logic         n_neg0 [gcd_pkg::LANES];

    genvar k, l;

    generate
        for (l = 0; l < gcd_pkg::LANES; l++) begin : g_lane
            // Fold angles beyond a quarter turn by a half turn; results are negated later.
            always_comb begin
                gcd_pkg::t_zw zi;
                zi = gcd_pkg::t_zw'(i_angle[l]);
                n_z0[l]   = zi;
                n_neg0[l] = 1'b0;
                if (zi > gcd_pkg::QUARTER) begin
                    n_z0[l]   = zi - gcd_pkg::HALF;
                    n_neg0[l] = 1'b1;
                end else if (zi < -gcd_pkg::QUARTER) begin
                    n_z0[l]   = zi + gcd_pkg::HALF;
                    n_neg0[l] = 1'b1;
                end
            end

            // Entry stage loads the start vector.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[0][l]   <= gcd_pkg::t_cw'(gcd_pkg::INV_GAIN);
                    r_y[0][l]   <= '0;
                    r_z[0][l]   <= n_z0[l];
                    r_neg[0][l] <= n_neg0[l];
                end
            end

            // One micro-rotation per stage.
            for (k = 0; k < gcd_pkg::ITER; k++) begin : g_step
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_neg[k+1][l] <= r_neg[k][l];
                        if (r_z[k][l] >= 0) begin
                            r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                            r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                            r_z[k+1][l] <= r_z[k][l] - gcd_pkg::atan_step(k);
                        end else begin
                            r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                            r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                            r_z[k+1][l] <= r_z[k][l] + gcd_pkg::atan_step(k);
                        end
                    end
                end
            end
        end
    endgenerate

    // Output stage: sines of the differences, cosines of the latitudes.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin[0] <= r_neg[gcd_pkg::ITER][0] ? -r_y[gcd_pkg::ITER][0] : r_y[gcd_pkg::ITER][0];
            r_sin[1] <= r_neg[gcd_pkg::ITER][1] ? -r_y[gcd_pkg::ITER][1] : r_y[gcd_pkg::ITER][1];
            r_cos[0] <= r_neg[gcd_pkg::ITER][2] ? -r_x[gcd_pkg::ITER][2] : r_x[gcd_pkg::ITER][2];
            r_cos[1] <= r_neg[gcd_pkg::ITER][3] ? -r_x[gcd_pkg::ITER][3] : r_x[gcd_pkg::ITER][3];
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_valid     <= {r_valid[gcd_pkg::ITER-1:0], i_valid};
            r_out_valid <= r_valid[gcd_pkg::ITER];
        end
    end

    assign o_valid = r_out_valid;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

/* src/gcd_hav.sv */
// Haversine term a = sin^2(dlat/2) + sin^2(dlon/2) cos(lat_a) cos(lat_b), clamped to [0, 1].
module gcd_hav (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  gcd_pkg::t_cw   i_sin [2],
    input  gcd_pkg::t_cw   i_cos [2],
    output logic           o_valid,
    output gcd_pkg::t_frac o_a
);

    gcd_pkg::t_prod r1_p11, r1_p22, r3_p, r5_p;
    gcd_pkg::t_cw   r1_ca, r1_cb, r2_q1, r2_q2, r2_ca, r2_cb;
    gcd_pkg::t_cw   r3_q1, r3_cb, r4_q, r4_q1, r4_cb, r5_q1, r6_q, r6_q1;
    logic           r3_neg, r5_neg;
    gcd_pkg::t_frac r7_a;
    logic [6:0]     r_valid;
    gcd_pkg::t_cw   n_sum;
    gcd_pkg::t_frac n_a;

    // Sum and clamp of the two terms.
    always_comb begin
        n_sum = r6_q1 + r6_q;
        if (n_sum < 0) begin
            n_a = '0;
        end else if (n_sum > gcd_pkg::t_cw'(gcd_pkg::ONE)) begin
            n_a = gcd_pkg::ONE;
        end else begin
            n_a = gcd_pkg::t_frac'(n_sum);
        end
    end

    // Alternating multiply and round stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p11 <= gcd_pkg::t_prod'(gcd_pkg::mag(i_sin[0])) *
                      gcd_pkg::t_prod'(gcd_pkg::mag(i_sin[0]));
            r1_p22 <= gcd_pkg::t_prod'(gcd_pkg::mag(i_sin[1])) *
                      gcd_pkg::t_prod'(gcd_pkg::mag(i_sin[1]));
            r1_ca  <= i_cos[0];
            r1_cb  <= i_cos[1];

            r2_q1  <= gcd_pkg::qround(r1_p11, 1'b0);
            r2_q2  <= gcd_pkg::qround(r1_p22, 1'b0);
            r2_ca  <= r1_ca;
            r2_cb  <= r1_cb;

            r3_p   <= gcd_pkg::t_prod'(gcd_pkg::mag(r2_q2)) *
                      gcd_pkg::t_prod'(gcd_pkg::mag(r2_ca));
            r3_neg <= r2_q2[gcd_pkg::CW-1] != r2_ca[gcd_pkg::CW-1];
            r3_q1  <= r2_q1;
            r3_cb  <= r2_cb;

            r4_q   <= gcd_pkg::qround(r3_p, r3_neg);
            r4_q1  <= r3_q1;
            r4_cb  <= r3_cb;

            r5_p   <= gcd_pkg::t_prod'(gcd_pkg::mag(r4_q)) *
                      gcd_pkg::t_prod'(gcd_pkg::mag(r4_cb));
            r5_neg <= r4_q[gcd_pkg::CW-1] != r4_cb[gcd_pkg::CW-1];
            r5_q1  <= r4_q1;

            r6_q   <= gcd_pkg::qround(r5_p, r5_neg);
            r6_q1  <= r5_q1;

            r7_a   <= n_a;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[5:0], i_valid};
        end
    end

    assign o_valid = r_valid[6];
    assign o_a     = r7_a;

endmodule

/* src/gcd_sqrt.sv */
// Two-lane pipelined floor square root of a and 1 - a, one result bit per stage.
module gcd_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  gcd_pkg::t_frac i_a,
    output logic           o_valid,
    output gcd_pkg::t_root o_y,
    output gcd_pkg::t_root o_x
);

    localparam int SHIFT = 62 - gcd_pkg::FRAC_BITS;

    gcd_pkg::t_sq r_v [gcd_pkg::ITER+1][2];
    gcd_pkg::t_sq r_r [gcd_pkg::ITER+1][2];
    logic [gcd_pkg::ITER:0] r_valid;

    genvar k, l;

    // Entry stage scales both operands to the top of the word.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0][0] <= gcd_pkg::t_sq'(i_a) << SHIFT;
            r_v[0][1] <= gcd_pkg::t_sq'(gcd_pkg::ONE - i_a) << SHIFT;
            r_r[0][0] <= '0;
            r_r[0][1] <= '0;
        end
    end

    // Restoring square root: one trial subtraction per stage and lane.
    generate
        for (k = 0; k < gcd_pkg::ITER; k++) begin : g_step
            for (l = 0; l < 2; l++) begin : g_lane
                localparam gcd_pkg::t_sq BIT = gcd_pkg::t_sq'(1) << (62 - 2 * k);
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        if (r_v[k][l] >= r_r[k][l] + BIT) begin
                            r_v[k+1][l] <= r_v[k][l] - (r_r[k][l] + BIT);
                            r_r[k+1][l] <= (r_r[k][l] >> 1) + BIT;
                        end else begin
                            r_v[k+1][l] <= r_v[k][l];
                            r_r[k+1][l] <= r_r[k][l] >> 1;
                        end
                    end
                end
            end
        end
    endgenerate

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[gcd_pkg::ITER-1:0], i_valid};
        end
    end

    assign o_valid = r_valid[gcd_pkg::ITER];
    assign o_y     = r_r[gcd_pkg::ITER][0][gcd_pkg::RW-1:0];
    assign o_x     = r_r[gcd_pkg::ITER][1][gcd_pkg::RW-1:0];

endmodule

/* src/gcd_atan.sv */
// Unrolled vectoring CORDIC giving the central angle, clamped to half a turn.
module gcd_atan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  gcd_pkg::t_root i_x,
    input  gcd_pkg::t_root i_y,
    output logic           o_valid,
    output logic [31:0]    o_theta
);

    gcd_pkg::t_vw r_x [gcd_pkg::ITER+1];
    gcd_pkg::t_vw r_y [gcd_pkg::ITER+1];
    gcd_pkg::t_zw r_z [gcd_pkg::ITER+1];
    logic [gcd_pkg::ITER:0] r_valid;
    logic         r_out_valid;
    logic [31:0]  r_theta;
    logic [31:0]  n_theta;

    genvar k;

    // Entry stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= gcd_pkg::t_vw'(i_x);
            r_y[0] <= gcd_pkg::t_vw'(i_y);
            r_z[0] <= '0;
        end
    end

    // One micro-rotation per stage, driving y towards zero.
    generate
        for (k = 0; k < gcd_pkg::ITER; k++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (r_y[k] > 0) begin
                        r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                        r_z[k+1] <= r_z[k] + gcd_pkg::atan_step(k);
                    end else begin
                        r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                        r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                        r_z[k+1] <= r_z[k] - gcd_pkg::atan_step(k);
                    end
                end
            end
        end
    endgenerate

    // Clamp the angle to [0, half a turn].
    always_comb begin
        if (r_z[gcd_pkg::ITER] < 0) begin
            n_theta = '0;
        end else if (r_z[gcd_pkg::ITER] > gcd_pkg::QUARTER) begin
            n_theta = 32'(gcd_pkg::QUARTER);
        end else begin
            n_theta = 32'(r_z[gcd_pkg::ITER]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_theta <= n_theta;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_valid     <= {r_valid[gcd_pkg::ITER-1:0], i_valid};
            r_out_valid <= r_valid[gcd_pkg::ITER];
        end
    end

    assign o_valid = r_out_valid;
    assign o_theta = r_theta;

endmodule

/* src/great_circle_distance_top.sv */
// Top level of the great circle distance pipeline with radius register and output stage.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while the output register is full and the consumer is not ready.
// Reset (synchronous, active low) empties the pipeline and sets the radius to 6371000 m.
module great_circle_distance_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_lat_a,
    input  logic [31:0] i_lon_a,
    input  logic [31:0] i_lat_b,
    input  logic [31:0] i_lon_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [25:0] o_distance_m,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data
);

    logic                   en;
    logic [gcd_pkg::RADW-1:0] r_radius;
    logic                   r0_valid;
    gcd_pkg::t_ang          r0_ang [gcd_pkg::LANES];
    logic                   sc_valid;
    gcd_pkg::t_cw           sc_sin [2];
    gcd_pkg::t_cw           sc_cos [2];
    logic                   hav_valid;
    gcd_pkg::t_frac         hav_a;
    logic                   sq_valid;
    gcd_pkg::t_root         sq_y, sq_x;
    logic                   atan_valid;
    logic [31:0]            theta;
    logic                   r_f1_valid, r_f2_valid, r_out_valid;
    logic [63:0]            r_f1_prod;
    logic [55:0]            r_f2_lo, r_f2_hm;
    logic [gcd_pkg::DISTW-1:0] r_dist;
    logic [56:0]            n_hi;
    logic [27:0]            n_d;

    // The pipeline moves whenever the output register can take a new value.
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    // Radius register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= gcd_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    // Input stage: angle differences and doubled latitudes in units of 2^-33 turn.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_ang[0] <= gcd_pkg::t_ang'(signed'(i_lat_b - i_lat_a));
            r0_ang[1] <= gcd_pkg::t_ang'(signed'(i_lon_b - i_lon_a));
            r0_ang[2] <= gcd_pkg::t_ang'({i_lat_a, 1'b0});
            r0_ang[3] <= gcd_pkg::t_ang'({i_lat_b, 1'b0});
        end
    end

    gcd_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_valid),
        .i_angle (r0_ang),
        .o_valid (sc_valid),
        .o_sin   (sc_sin),
        .o_cos   (sc_cos)
    );

    gcd_hav u_hav (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sc_valid),
        .i_sin   (sc_sin),
        .i_cos   (sc_cos),
        .o_valid (hav_valid),
        .o_a     (hav_a)
    );

    gcd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (hav_valid),
        .i_a     (hav_a),
        .o_valid (sq_valid),
        .o_y     (sq_y),
        .o_x     (sq_x)
    );

    gcd_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_x     (sq_x),
        .i_y     (sq_y),
        .o_valid (atan_valid),
        .o_theta (theta)
    );

    // Scale to metres: theta * 2pi, then times the radius in two partial products.
    assign n_hi = 57'(r_f2_hm) + 57'(r_f2_lo >> 32);
    assign n_d  = 28'((n_hi + (57'd1 << 28)) >> 29);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_prod <= 64'(theta) * 64'(gcd_pkg::TWO_PI_Q29);
            r_f2_lo   <= 56'(r_radius) * 56'(r_f1_prod[31:0]);
            r_f2_hm   <= 56'(r_radius) * 56'(r_f1_prod[63:32]);
            r_dist    <= (n_d > 28'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                        : n_d[gcd_pkg::DISTW-1:0];
        end
    end

    // Valid bits of the input, scaling and output stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid    <= 1'b0;
            r_f1_valid  <= 1'b0;
            r_f2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r0_valid    <= i_valid;
            r_f1_valid  <= atan_valid;
            r_f2_valid  <= r_f1_valid;
            r_out_valid <= r_f2_valid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_distance_m = r_dist;

`ifndef SYNTHESIS
    a_hav_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hav_valid |-> (hav_a <= gcd_pkg::ONE))
        else $error("haversine term above one");

    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        atan_valid |-> (theta <= 32'h80000000))
        else $error("central angle beyond half a turn");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");
`endif

endmodule
